FILE: rtl/mhp_pkg.sv
// Shared types and constants of the MOT header parser.
package mhp_pkg;

  // Default cap on emitted content-name bytes.
  localparam int NAME_LIMIT_DEF = 31;

  // Depth of the result queue; a power of two, at least two.
  localparam int RES_DEPTH = 4;

  localparam int POS_W = 13;
  localparam logic [POS_W-1:0] POS_MAX = 13'h1FFF;
  localparam logic [POS_W-1:0] CORE_LEN = 13'd7;

  // PLI classes of an extension parameter.
  localparam logic [1:0] PLI_NONE = 2'd0;
  localparam logic [1:0] PLI_ONE = 2'd1;
  localparam logic [1:0] PLI_FOUR = 2'd2;
  localparam logic [1:0] PLI_VAR = 2'd3;

  localparam logic [5:0] PARAM_CONTENT_NAME = 6'd12;

  // Result kinds.
  localparam logic KIND_NAME = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_char;
    logic [3:0]  name_charset;
    logic [4:0]  name_pos;
    logic [12:0] hdr_size;
    logic [27:0] obj_body_size;
    logic [5:0]  content_kind;
    logic [8:0]  content_sub;
    logic        core_ok;
  } mhp_result_t;

  typedef struct packed {
    logic        vld;
    mhp_result_t data;
  } mhp_res_req_t;

endpackage

FILE: rtl/mhp_ifs.sv
// Valid/ready channel interfaces for header bytes and parser results.
interface mhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface mhp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  name_char;
  logic [3:0]  name_charset;
  logic [4:0]  name_pos;
  logic [12:0] hdr_size;
  logic [27:0] obj_body_size;
  logic [5:0]  content_kind;
  logic [8:0]  content_sub;
  logic        core_ok;

  modport source (
    output valid, output kind, output name_char, output name_charset, output name_pos,
    output hdr_size, output obj_body_size, output content_kind, output content_sub,
    output core_ok, input ready
  );
  modport sink (
    input valid, input kind, input name_char, input name_charset, input name_pos,
    input hdr_size, input obj_body_size, input content_kind, input content_sub,
    input core_ok, output ready
  );
endinterface

FILE: rtl/mhp_parse.sv
// Per-byte header state machine: core field capture, parameter skipping, name extraction.
module mhp_parse
  import mhp_pkg::*;
#(
  parameter int NAME_LIMIT = NAME_LIMIT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [7:0]   byte_in,
  input  logic         last_byte,
  output mhp_res_req_t res_name,
  output mhp_res_req_t res_sum
);

  localparam int CNT_W = $clog2(NAME_LIMIT + 1);

  typedef enum logic [2:0] {
    PH_CORE, PH_START, PH_LEN1, PH_LEN2, PH_SKIP, PH_CHARSET, PH_NAME, PH_DONE
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   byte_pos_r, byte_pos_nxt;
  logic [14:0]        skip_left_r, skip_left_nxt;
  logic [6:0]         len_high_r, len_high_nxt;
  logic [5:0]         param_code_r, param_code_nxt;
  logic [12:0]        hdr_r, hdr_nxt;
  logic [27:0]        body_r, body_nxt;
  logic [14:0]        type_r, type_nxt;
  logic [3:0]         charset_r, charset_nxt;
  logic [CNT_W-1:0]   name_count_r, name_count_nxt;
  logic [14:0]        body_len;
  logic               body_start;
  logic               emit_name;

  always_comb begin
    phase_nxt = phase_r;
    skip_left_nxt = skip_left_r;
    len_high_nxt = len_high_r;
    param_code_nxt = param_code_r;
    hdr_nxt = hdr_r;
    body_nxt = body_r;
    type_nxt = type_r;
    charset_nxt = charset_r;
    name_count_nxt = name_count_r;
    body_len = '0;
    body_start = 1'b0;
    emit_name = 1'b0;

    case (phase_r)
      PH_CORE: begin
        case (byte_pos_r)
          13'd0: body_nxt = body_r | {byte_in, 20'd0};
          13'd1: body_nxt = body_r | {8'd0, byte_in, 12'd0};
          13'd2: body_nxt = body_r | {16'd0, byte_in, 4'd0};
          13'd3: begin
            body_nxt = body_r | {24'd0, byte_in[7:4]};
            hdr_nxt = hdr_r | {byte_in[3:0], 9'd0};
          end
          13'd4: hdr_nxt = hdr_r | {4'd0, byte_in, 1'b0};
          13'd5: begin
            hdr_nxt = hdr_r | {12'd0, byte_in[7]};
            type_nxt = type_r | {byte_in[6:1], byte_in[0], 8'd0};
          end
          default: begin
            type_nxt = type_r | {7'd0, byte_in};
            phase_nxt = PH_START;
          end
        endcase
      end
      PH_START: begin
        if (byte_pos_r >= hdr_r) begin
          phase_nxt = PH_DONE;
        end else begin
          param_code_nxt = byte_in[5:0];
          case (byte_in[7:6])
            PLI_NONE: ;
            PLI_ONE: begin
              skip_left_nxt = 15'd1;
              phase_nxt = PH_SKIP;
            end
            PLI_FOUR: begin
              skip_left_nxt = 15'd4;
              phase_nxt = PH_SKIP;
            end
            default: phase_nxt = PH_LEN1;
          endcase
        end
      end
      PH_LEN1: begin
        if (byte_in[7]) begin
          len_high_nxt = byte_in[6:0];
          phase_nxt = PH_LEN2;
        end else begin
          body_len = {8'd0, byte_in[6:0]};
          body_start = 1'b1;
        end
      end
      PH_LEN2: begin
        body_len = {len_high_r, byte_in};
        body_start = 1'b1;
      end
      PH_SKIP: begin
        skip_left_nxt = skip_left_r - 15'd1;
        if (skip_left_nxt == '0) phase_nxt = PH_START;
      end
      PH_CHARSET: begin
        charset_nxt = byte_in[7:4];
        name_count_nxt = '0;
        skip_left_nxt = skip_left_r - 15'd1;
        phase_nxt = (skip_left_nxt == '0) ? PH_START : PH_NAME;
      end
      PH_NAME: begin
        if (name_count_r < CNT_W'(NAME_LIMIT)) begin
          name_count_nxt = name_count_r + 1'b1;
          emit_name = 1'b1;
        end
        skip_left_nxt = skip_left_r - 15'd1;
        if (skip_left_nxt == '0) phase_nxt = PH_START;
      end
      default: ;
    endcase

    // A zero-length body goes straight on to the next parameter.
    if (body_start) begin
      skip_left_nxt = body_len;
      if (body_len == '0) phase_nxt = PH_START;
      else if (param_code_r == PARAM_CONTENT_NAME) phase_nxt = PH_CHARSET;
      else phase_nxt = PH_SKIP;
    end

    byte_pos_nxt = (byte_pos_r != POS_MAX) ? byte_pos_r + 1'b1 : byte_pos_r;
  end

  always_comb begin
    res_name.vld = go && emit_name;
    res_name.data = '0;
    res_name.data.kind = KIND_NAME;
    res_name.data.name_char = byte_in;
    res_name.data.name_charset = charset_r;
    res_name.data.name_pos = 5'(name_count_nxt);

    res_sum.vld = go && last_byte;
    res_sum.data = '0;
    res_sum.data.kind = KIND_SUMMARY;
    res_sum.data.hdr_size = hdr_nxt;
    res_sum.data.obj_body_size = body_nxt;
    res_sum.data.content_kind = type_nxt[14:9];
    res_sum.data.content_sub = type_nxt[8:0];
    res_sum.data.core_ok = (byte_pos_nxt >= CORE_LEN);
  end

  // The last byte of a segment returns the parser to its reset state.
  always_ff @(posedge clk) begin
    if (!rst_n || (go && last_byte)) begin
      phase_r <= PH_CORE;
      byte_pos_r <= '0;
      skip_left_r <= '0;
      len_high_r <= '0;
      param_code_r <= '0;
      hdr_r <= '0;
      body_r <= '0;
      type_r <= '0;
      charset_r <= '0;
      name_count_r <= '0;
    end else if (go) begin
      phase_r <= phase_nxt;
      byte_pos_r <= byte_pos_nxt;
      skip_left_r <= skip_left_nxt;
      len_high_r <= len_high_nxt;
      param_code_r <= param_code_nxt;
      hdr_r <= hdr_nxt;
      body_r <= body_nxt;
      type_r <= type_nxt;
      charset_r <= charset_nxt;
      name_count_r <= name_count_nxt;
    end
  end

  a_name_only_in_name_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res_name.vld |-> phase_r == PH_NAME)
    else $error("name byte emitted outside the name phase");

  a_segment_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (go && last_byte) |=> (phase_r == PH_CORE && byte_pos_r == '0))
    else $error("parser state not cleared after the last byte of a segment");

endmodule

FILE: rtl/mhp_res_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
module mhp_res_fifo
  import mhp_pkg::*;
#(
  parameter int DEPTH = RES_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  mhp_res_req_t push_a,
  input  mhp_res_req_t push_b,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output mhp_result_t  out_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mhp_result_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_b_ptr;
  logic [CNT_W-1:0] count_r, push_n;
  logic             pop;

  assign push_n = CNT_W'(push_a.vld) + CNT_W'(push_b.vld);
  assign pop = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data = mem_r[rd_ptr_r];
  // Room means a byte carrying both a name byte and a summary still fits.
  assign room = (count_r <= CNT_W'(DEPTH - 2));
  assign wr_b_ptr = push_a.vld ? wr_ptr_r + 1'b1 : wr_ptr_r;

  always_ff @(posedge clk) begin
    if (push_a.vld) mem_r[wr_ptr_r] <= push_a.data;
    if (push_b.vld) mem_r[wr_b_ptr] <= push_b.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + push_n - CNT_W'(pop);
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("result queue count out of range");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_a.vld || push_b.vld) |-> room)
    else $error("result pushed without two free entries");

endmodule

FILE: rtl/mot_header_parser_core.sv
// Top level of the MOT header parser: input register, parser and result queue.
//
// The parser takes one header byte per cycle while the result queue has room,
// and returns to its reset state after the byte flagged as last. A byte
// enters an input register, is parsed from there, and its results go into a
// four-entry result queue whose head is offered on the output. Each
// content-name byte up to the name cap gives one result and the last byte
// adds a summary, so one byte can give two results. A byte is parsed only
// while the queue has two free entries; with the output side taking one
// result per cycle a new byte is accepted in every cycle.
module mot_header_parser_core
  import mhp_pkg::*;
#(
  parameter int NAME_LIMIT = NAME_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mhp_in_if.sink      in_chan,
  mhp_out_if.source   out_chan
);

  logic         s1_vld_r;
  logic [7:0]   s1_byte_r;
  logic         s1_last_r;
  logic         room;
  logic         go;
  mhp_res_req_t res_name, res_sum;
  mhp_result_t  head;

  assign go = s1_vld_r && room;
  assign in_chan.ready = !s1_vld_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_byte_r <= in_chan.byte_in;
      s1_last_r <= in_chan.last_byte;
    end
  end

  mhp_parse #(
    .NAME_LIMIT(NAME_LIMIT)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .byte_in  (s1_byte_r),
    .last_byte(s1_last_r),
    .res_name (res_name),
    .res_sum  (res_sum)
  );

  mhp_res_fifo #(
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_a   (res_name),
    .push_b   (res_sum),
    .room     (room),
    .out_valid(out_chan.valid),
    .out_ready(out_chan.ready),
    .out_data (head)
  );

  assign out_chan.kind = head.kind;
  assign out_chan.name_char = head.name_char;
  assign out_chan.name_charset = head.name_charset;
  assign out_chan.name_pos = head.name_pos;
  assign out_chan.hdr_size = head.hdr_size;
  assign out_chan.obj_body_size = head.obj_body_size;
  assign out_chan.content_kind = head.content_kind;
  assign out_chan.content_sub = head.content_sub;
  assign out_chan.core_ok = head.core_ok;

endmodule

FILE: tb/sv/mot_header_parser_core_tb.sv
// Testbench for the MOT header parser core: segment stimulus, bytewise predictor and scoreboard.
`timescale 1ns / 1ps

module mot_header_parser_core_tb
  import mhp_pkg::*;
();

  localparam int NAME_CAP = NAME_LIMIT_DEF;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [2:0] {
    ST_CORE,
    ST_PARAM,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_SKIP,
    ST_CHARSET,
    ST_NAME,
    ST_DONE
  } parse_st_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } hdr_byte_t;

  logic clk;
  logic rst_n;

  mhp_in_if  in_chan ();
  mhp_out_if out_chan ();

  mot_header_parser_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  hdr_byte_t   byte_stream[$];
  mhp_result_t results_due[$];
  logic [7:0]  seg[$];
  logic [7:0]  parm[$];
  int          queued;
  int          mismatch_cnt;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_arm;
  logic        hold_taken;
  int          hold_cnt;

  // Predicted parser state.
  parse_st_t   pst;
  logic [12:0] pos;
  logic [12:0] hdr_sz;
  logic [27:0] body_sz;
  logic [14:0] type_w;
  logic [14:0] skip;
  logic [6:0]  len_hi;
  logic [5:0]  pcode;
  logic [3:0]  cset;
  logic [4:0]  ncnt;

  task automatic clear_state();
    pst = ST_CORE;
    pos = '0;
    hdr_sz = '0;
    body_sz = '0;
    type_w = '0;
    skip = '0;
    len_hi = '0;
    pcode = '0;
    cset = '0;
    ncnt = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    mhp_result_t r;
    logic [14:0] blen;
    logic        open_body;
    open_body = 1'b0;
    blen = '0;
    case (pst)
      ST_CORE: begin
        case (pos)
          13'd0: body_sz[27:20] = body_sz[27:20] | b;
          13'd1: body_sz[19:12] = body_sz[19:12] | b;
          13'd2: body_sz[11:4] = body_sz[11:4] | b;
          13'd3: begin
            body_sz[3:0] = body_sz[3:0] | b[7:4];
            hdr_sz[12:9] = hdr_sz[12:9] | b[3:0];
          end
          13'd4: hdr_sz[8:1] = hdr_sz[8:1] | b;
          13'd5: begin
            hdr_sz[0] = hdr_sz[0] | b[7];
            type_w[14:9] = type_w[14:9] | b[6:1];
            type_w[8] = type_w[8] | b[0];
          end
          default: begin
            type_w[7:0] = type_w[7:0] | b;
            pst = ST_PARAM;
          end
        endcase
      end
      ST_PARAM: begin
        // Only a parameter whose first byte lies inside the header is parsed.
        if (pos >= hdr_sz) begin
          pst = ST_DONE;
        end else begin
          pcode = b[5:0];
          case (b[7:6])
            PLI_NONE: ;
            PLI_ONE: begin
              skip = 15'd1;
              pst = ST_SKIP;
            end
            PLI_FOUR: begin
              skip = 15'd4;
              pst = ST_SKIP;
            end
            default: pst = ST_LEN_HI;
          endcase
        end
      end
      ST_LEN_HI: begin
        if (b[7]) begin
          len_hi = b[6:0];
          pst = ST_LEN_LO;
        end else begin
          blen = {8'd0, b[6:0]};
          open_body = 1'b1;
        end
      end
      ST_LEN_LO: begin
        blen = {len_hi, b};
        open_body = 1'b1;
      end
      ST_SKIP: begin
        skip = skip - 15'd1;
        if (skip == '0) pst = ST_PARAM;
      end
      ST_CHARSET: begin
        cset = b[7:4];
        ncnt = '0;
        skip = skip - 15'd1;
        pst = (skip == '0) ? ST_PARAM : ST_NAME;
      end
      ST_NAME: begin
        if (ncnt < NAME_CAP) begin
          ncnt = ncnt + 5'd1;
          r = '0;
          r.kind = KIND_NAME;
          r.name_char = b;
          r.name_charset = cset;
          r.name_pos = ncnt;
          results_due.push_back(r);
        end
        skip = skip - 15'd1;
        if (skip == '0) pst = ST_PARAM;
      end
      default: ;
    endcase

    if (open_body) begin
      skip = blen;
      if (skip == '0) pst = ST_PARAM;
      else if (pcode == PARAM_CONTENT_NAME) pst = ST_CHARSET;
      else pst = ST_SKIP;
    end

    if (pos != POS_MAX) pos = pos + 13'd1;

    if (last) begin
      r = '0;
      r.kind = KIND_SUMMARY;
      r.hdr_size = hdr_sz;
      r.obj_body_size = body_sz;
      r.content_kind = type_w[14:9];
      r.content_sub = type_w[8:0];
      r.core_ok = (pos >= CORE_LEN);
      results_due.push_back(r);
      clear_state();
    end
  endtask

  function automatic string fmt_result(input mhp_result_t r);
    return $sformatf({"kind=%0d char=%02h cs=%0d npos=%0d hdr=%0d body=%0d",
                      " ct=%0d sub=%0d ok=%0d"},
                     r.kind, r.name_char, r.name_charset, r.name_pos, r.hdr_size,
                     r.obj_body_size, r.content_kind, r.content_sub, r.core_ok);
  endfunction

  task automatic push_core(input logic [27:0] bs, input logic [12:0] hs, input logic [5:0] ct,
                           input logic [8:0] cs);
    seg.push_back(bs[27:20]);
    seg.push_back(bs[19:12]);
    seg.push_back(bs[11:4]);
    seg.push_back({bs[3:0], hs[12:9]});
    seg.push_back(hs[8:1]);
    seg.push_back({hs[0], ct, cs[8]});
    seg.push_back(cs[7:0]);
  endtask

  task automatic flush_segment();
    hdr_byte_t hb;
    foreach (seg[i]) begin
      hb.data = seg[i];
      hb.last = (i == seg.size() - 1);
      byte_stream.push_back(hb);
    end
    queued += seg.size();
    seg.delete();
  endtask

  // Variable-length parameters use the long form when the length needs 15 bits, and at random otherwise.
  task automatic put_length(input logic [14:0] len);
    if (len > 15'd127 || $urandom_range(3) == 0) begin
      parm.push_back({1'b1, len[14:8]});
      parm.push_back(len[7:0]);
    end else begin
      parm.push_back({1'b0, len[6:0]});
    end
  endtask

  task automatic random_segment();
    logic [14:0] plen;
    logic [12:0] hs;
    logic [5:0]  pid;
    int          sel;
    int          nlen;
    int          cut;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 24)) seg.push_back(8'($urandom()));
    end else begin
      repeat ($urandom_range(0, 4)) begin
        sel = $urandom_range(99);
        if (sel < 40) begin
          nlen = ($urandom_range(9) == 0) ? $urandom_range(32, 45) : $urandom_range(0, 8);
          plen = (nlen == 0 && $urandom_range(1) == 1) ? 15'd0 : 15'(nlen + 1);
          parm.push_back({PLI_VAR, PARAM_CONTENT_NAME});
          put_length(plen);
          repeat (plen) parm.push_back(8'($urandom()));
        end else if (sel < 55) begin
          parm.push_back({PLI_NONE, 6'($urandom())});
        end else if (sel < 70) begin
          parm.push_back({PLI_ONE, 6'($urandom())});
          parm.push_back(8'($urandom()));
        end else if (sel < 82) begin
          parm.push_back({PLI_FOUR, 6'($urandom())});
          repeat (4) parm.push_back(8'($urandom()));
        end else begin
          pid = 6'($urandom());
          if (pid == PARAM_CONTENT_NAME) pid = pid + 6'd1;
          plen = 15'($urandom_range(0, 6));
          parm.push_back({PLI_VAR, pid});
          put_length(plen);
          repeat (plen) parm.push_back(8'($urandom()));
        end
      end
      sel = $urandom_range(99);
      if (sel < 10) hs = 13'($urandom_range(0, 6));
      else if (sel < 20) hs = 13'($urandom_range(7, 7 + parm.size()));
      else if (sel < 25) hs = 13'($urandom());
      else hs = 13'(7 + parm.size());
      push_core(28'($urandom()), hs, 6'($urandom()), 9'($urandom()));
      foreach (parm[i]) seg.push_back(parm[i]);
      parm.delete();
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) seg.push_back(8'($urandom()));
      // Now and then the segment ends in the middle of its structure.
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(1, seg.size());
        while (seg.size() > cut) void'(seg.pop_back());
      end
    end
    flush_segment();
  endtask

  task automatic fill(input int n);
    int target;
    target = queued + n;
    while (queued < target) random_segment();
  endtask

  task automatic wait_drained();
    while (byte_stream.size() != 0 || in_chan.valid || results_due.size() != 0) @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sender: a request stays up until it is taken, then the next byte follows.
  always @(posedge clk) begin : byte_sender
    hdr_byte_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (in_chan.valid) parse_byte(in_chan.byte_in, in_chan.last_byte);
      if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = byte_stream.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.byte_in <= nxt.data;
        in_chan.last_byte <= nxt.last;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : hold_timer
    if (hold_arm && !hold_taken) begin
      hold_cnt <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin : result_checker
    mhp_result_t got;
    mhp_result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.kind = out_chan.kind;
        got.name_char = out_chan.name_char;
        got.name_charset = out_chan.name_charset;
        got.name_pos = out_chan.name_pos;
        got.hdr_size = out_chan.hdr_size;
        got.obj_body_size = out_chan.obj_body_size;
        got.content_kind = out_chan.content_kind;
        got.content_sub = out_chan.content_sub;
        got.core_ok = out_chan.core_ok;
        if (results_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("result with nothing pending: %s", fmt_result(got));
        end else begin
          want = results_due.pop_front();
          if (got.kind !== want.kind || got.name_char !== want.name_char ||
              got.name_charset !== want.name_charset || got.name_pos !== want.name_pos ||
              got.hdr_size !== want.hdr_size || got.obj_body_size !== want.obj_body_size ||
              got.content_kind !== want.content_kind ||
              got.content_sub !== want.content_sub || got.core_ok !== want.core_ok) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
          end
        end
      end
      out_chan.ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.byte_in = '0;
    in_chan.last_byte = 1'b0;
    out_chan.ready = 1'b0;
    rst_n = 1'b0;
    hold_arm = 1'b0;
    hold_taken = 1'b0;
    hold_cnt = 0;
    queued = 0;
    mismatch_cnt = 0;
    set_idling(0, 0);
    clear_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Segment of a single byte.
    seg.push_back(8'hFF);
    flush_segment();
    // Core cut short after six bytes.
    seg.push_back(8'h12); seg.push_back(8'h34); seg.push_back(8'h56);
    seg.push_back(8'h78); seg.push_back(8'h9A); seg.push_back(8'hBC);
    flush_segment();
    // Header size of zero: the name parameter after the core is ignored.
    push_core('0, '0, '0, '0);
    seg.push_back(8'hCC); seg.push_back(8'h02);
    flush_segment();
    // All-ones core followed by a name with extreme byte values.
    push_core('1, '1, '1, '1);
    seg.push_back(8'hCC); seg.push_back(8'h04); seg.push_back(8'hF0);
    seg.push_back(8'h00); seg.push_back(8'hFF); seg.push_back(8'h41);
    flush_segment();
    // Fixed-size classes; the four-byte one starts just past the header and is not parsed.
    push_core(28'h0123456, 13'd10, 6'd2, 9'd3);
    seg.push_back(8'h05); seg.push_back(8'h4A); seg.push_back(8'h55);
    seg.push_back(8'h81); seg.push_back(8'h11); seg.push_back(8'h22);
    seg.push_back(8'h33); seg.push_back(8'h44); seg.push_back(8'hCC);
    flush_segment();
    // Zero-length names in both length forms, then a charset-only name.
    push_core(28'h0000010, 13'd20, 6'd5, 9'd0);
    seg.push_back(8'hCC); seg.push_back(8'h00);
    seg.push_back(8'hCC); seg.push_back(8'h80); seg.push_back(8'h00);
    seg.push_back(8'hCC); seg.push_back(8'h01); seg.push_back(8'h50);
    flush_segment();
    // Name longer than the cap, in the 15-bit length form.
    push_core(28'h8000000, 13'd60, 6'd1, 9'd256);
    seg.push_back(8'hCC); seg.push_back(8'h80); seg.push_back(8'h23); seg.push_back(8'h30);
    for (int i = 0; i < 34; i++) seg.push_back(8'(8'h61 + i));
    seg.push_back(8'h00);
    flush_segment();
    // Name parameter cut off by the end of the segment.
    push_core(28'h0000001, 13'd30, 6'd63, 9'd511);
    seg.push_back(8'hCC); seg.push_back(8'h0A); seg.push_back(8'h10); seg.push_back(8'h61);
    flush_segment();
    wait_drained();

    set_idling(0, 0);
    fill(330);
    wait_drained();
    set_idling(45, 0);
    fill(330);
    wait_drained();
    set_idling(0, 45);
    fill(330);
    wait_drained();
    set_idling(20, 20);
    fill(330);
    wait_drained();

    // Long receiver hold-off while requests keep coming, so the block backs up.
    set_idling(0, 0);
    fill(150);
    hold_arm = 1'b1;
    wait_drained();

    repeat (20) @(negedge clk);
    if (mismatch_cnt == 0 && results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
